// ===== hdl/wtsp_pkg.sv =====
// shared types and constants for the world-to-screen projection block
// no dependencies
package wtsp_pkg;

    localparam int MAT_DIM     = 4;
    localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
    localparam int IDX_W       = 4;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 48;               // floor(coef*coord / 2^16)
    localparam int CLIP_W      = 49;               // sum of three products and a constant
    localparam int MAG_W       = CLIP_W - 1;       // magnitude of a clip value
    localparam int QUO_W       = 47;               // quotient bits per divide
    localparam int DX_FRAC     = 16;
    localparam int DZ_FRAC     = 30;
    localparam int DVD_W       = MAG_W + DZ_FRAC;  // widest dividend
    localparam int REM_W       = MAG_W + 1;
    localparam int DIV_STAGES  = QUO_W + 2;        // setup, one stage per bit, sign fixup
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int PIX_W       = 65;               // (1 +- d) * size
    localparam int PIXC_W      = 49;               // clamped value
    localparam int SCALE_W     = PIXC_W + 17;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int VP_W        = 15;
    localparam int PRR_W       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRR       = 2'd2;

    localparam logic [VP_W-1:0]  VP_WIDTH_RST  = 15'd1024;
    localparam logic [VP_W-1:0]  VP_HEIGHT_RST = 15'd768;
    localparam logic [PRR_W-1:0] PRR_RST       = 16'd16384;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cz;
        logic signed [CLIP_W-1:0] cw;
    } t_clip;

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [FIFO_AW:0]     count;
    } t_fifo_status;

endpackage

// ===== hdl/world_to_screen_projection.sv =====
// top level of the world-to-screen projection block
// depends on wtsp_pkg, wtsp_front, wtsp_fifo, wtsp_back
//
// Projects world points through a loaded 4x4 matrix to screen pixels. Load
// beats (tuser 0) write one q16.16 coefficient and give no output; project
// beats (tuser 1) give one output beat each. Every entry must be loaded before
// the first project. The block takes one beat per cycle while the queue has
// room. A point passes through two front stages of multiply and sum, the
// four-entry queue, 49 stages of the three bit-per-stage dividers (one stage per
// quotient bit, 47 bits, plus setup and sign), and two stages of viewport
// multiply and pixel-ratio scaling. A loaded coefficient is used by a project
// beat taken in the next cycle. A zero clip w gives tuser 1 and zero data.
// Write the config registers only while the block is empty.
module world_to_screen_projection import wtsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [135:0]          s_axis_tdata,  // coef_index, coef_value, point_x, point_y, point_z, pad
    input  logic [0:0]            s_axis_tuser,  // action
    // output beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [95:0]           m_axis_tdata,  // screen_x, screen_y, depth
    output logic [0:0]            m_axis_tuser,  // divide_fault
    // config writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [VP_W-1:0]  r_vp_width;
    logic [VP_W-1:0]  r_vp_height;
    logic [PRR_W-1:0] r_prr;

    logic          w_push;
    logic          w_pop;
    t_clip         w_clip_in;
    t_clip         w_clip_out;
    t_fifo_status  w_q_status;

    logic signed [COORD_W-1:0] w_sx;
    logic signed [COORD_W-1:0] w_sy;
    logic signed [COORD_W-1:0] w_dz;
    logic                      w_fault;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_width  <= VP_WIDTH_RST;
            r_vp_height <= VP_HEIGHT_RST;
            r_prr       <= PRR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VP_WIDTH:  r_vp_width  <= i_cfg_data[VP_W-1:0];
                REG_VP_HEIGHT: r_vp_height <= i_cfg_data[VP_W-1:0];
                REG_PRR:       r_prr       <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // front: matrix store and clip coordinates
    wtsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser[0]),
        .i_coef_index (s_axis_tdata[3:0]),
        .i_coef_value (s_axis_tdata[35:4]),
        .i_point_x    (s_axis_tdata[67:36]),
        .i_point_y    (s_axis_tdata[99:68]),
        .i_point_z    (s_axis_tdata[131:100]),
        .i_q_full     (w_q_status.full),
        .o_push       (w_push),
        .o_clip       (w_clip_in)
    );

    // queue lets the front keep taking beats while the back is held
    wtsp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_clip_in),
        .i_pop    (w_pop),
        .o_data   (w_clip_out),
        .o_status (w_q_status)
    );

    // back: divide, viewport map, output register
    wtsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clip      (w_clip_out),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .i_vp_width  (r_vp_width),
        .i_vp_height (r_vp_height),
        .i_prr       (r_prr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_screen_x  (w_sx),
        .o_screen_y  (w_sy),
        .o_depth     (w_dz),
        .o_fault     (w_fault)
    );

    assign m_axis_tdata = {w_dz, w_sy, w_sx};
    assign m_axis_tuser = w_fault;

    // a fault beat carries zero coordinates
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("fault beat with nonzero data");

    // queue never overfills and never pops empty
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.count <= (FIFO_AW+1)'(FIFO_DEPTH)) && !(w_pop && w_q_status.empty))
        else $error("queue bound broken");

    // the front only pushes when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("push into full queue");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ===== hdl/wtsp_front.sv =====
// front end: takes beats, loads the matrix store, computes clip coordinates
// depends on wtsp_pkg
module wtsp_front import wtsp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_action,
    input  logic [IDX_W-1:0]          i_coef_index,
    input  logic signed [COORD_W-1:0] i_coef_value,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic                      i_q_full,
    output logic                      o_push,
    output t_clip                     o_clip
);

    logic signed [COORD_W-1:0] r_mat [MAT_ENTRIES];
    logic signed [PROD_W-1:0]  r_prod [MAT_DIM][MAT_DIM-1];
    logic signed [COORD_W-1:0] r_ofs [MAT_DIM];
    logic                      r_s1_valid;
    logic                      r_s2_valid;
    t_clip                     r_clip;
    logic                      w_adv;
    logic                      w_acc;
    logic signed [COORD_W-1:0] w_pt [MAT_DIM-1];
    logic signed [CLIP_W-1:0]  w_sum [MAT_DIM];

    assign w_adv   = !r_s2_valid || !i_q_full;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;
    assign o_push  = r_s2_valid && w_adv;
    assign o_clip  = r_clip;

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // coefficient store, written by load beats
    always_ff @(posedge i_clk) begin
        if (w_acc && i_action == ACT_LOAD) begin
            r_mat[i_coef_index] <= i_coef_value;
        end
    end

    // stage 1: twelve products, floored to q16.16
    always_ff @(posedge i_clk) begin
        logic signed [2*COORD_W-1:0] v_p;
        if (w_adv) begin
            for (int r = 0; r < MAT_DIM; r++) begin
                for (int c = 0; c < MAT_DIM - 1; c++) begin
                    v_p = r_mat[r*MAT_DIM+c] * w_pt[c];
                    r_prod[r][c] <= v_p[2*COORD_W-1:2*COORD_W-PROD_W];
                end
                r_ofs[r] <= r_mat[r*MAT_DIM+MAT_DIM-1];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < MAT_DIM; r++) begin
            w_sum[r] = CLIP_W'(r_prod[r][0]) + CLIP_W'(r_prod[r][1])
                     + CLIP_W'(r_prod[r][2]) + CLIP_W'(r_ofs[r]);
        end
    end

    // stage 2: clip sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_clip.cx <= w_sum[0];
            r_clip.cy <= w_sum[1];
            r_clip.cz <= w_sum[2];
            r_clip.cw <= w_sum[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc && i_action == ACT_PROJECT;
            r_s2_valid <= r_s1_valid;
        end
    end

endmodule

// ===== hdl/wtsp_fifo.sv =====
// short queue of clip coordinates between front and back
// depends on wtsp_pkg
module wtsp_fifo import wtsp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_clip        i_data,
    input  logic         i_pop,
    output t_clip        o_data,
    output t_fifo_status o_status
);

    t_clip              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/wtsp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, truncation toward zero
// depends on wtsp_pkg
module wtsp_div import wtsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [CLIP_W-1:0] i_num,
    input  logic signed [CLIP_W-1:0] i_den,
    input  logic                     i_depth_mode,
    output logic signed [CLIP_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem  [QUO_W+1];
    logic [QUO_W-1:0] r_low  [QUO_W+1];
    logic [QUO_W-1:0] r_quo  [QUO_W+1];
    logic [MAG_W-1:0] r_den  [QUO_W+1];
    logic             r_neg  [QUO_W+1];
    logic             r_cap  [QUO_W+1];
    logic             r_mode [QUO_W+1];
    logic signed [CLIP_W-1:0] r_out;

    logic [MAG_W-1:0] w_un;
    logic [MAG_W-1:0] w_ud;
    logic [DVD_W-1:0] w_dvd;
    logic             w_cap;

    assign w_un = i_num[CLIP_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
    assign w_ud = i_den[CLIP_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);

    // integer part cap: 2 for depth, 2^31 for x and y
    always_comb begin
        if (i_depth_mode) begin
            w_dvd = {w_un, {DZ_FRAC{1'b0}}};
            w_cap = {1'b0, w_un} >= {w_ud, 1'b0};
        end else begin
            w_dvd = {{(DZ_FRAC-DX_FRAC){1'b0}}, w_un, {DX_FRAC{1'b0}}};
            w_cap = {31'd0, w_un} >= {w_ud, 31'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [REM_W-1:0] v_t;
        logic             v_ge;
        if (i_en) begin
            r_rem[0]  <= REM_W'(w_dvd[DVD_W-1:QUO_W]);
            r_low[0]  <= w_dvd[QUO_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= w_ud;
            r_neg[0]  <= i_num[CLIP_W-1] ^ i_den[CLIP_W-1];
            r_cap[0]  <= w_cap;
            r_mode[0] <= i_depth_mode;
            for (int s = 0; s < QUO_W; s++) begin
                v_t  = {r_rem[s][REM_W-2:0], r_low[s][QUO_W-1-s]};
                v_ge = v_t >= {1'b0, r_den[s]};
                r_rem[s+1]  <= v_ge ? v_t - {1'b0, r_den[s]} : v_t;
                r_quo[s+1]  <= {r_quo[s][QUO_W-2:0], v_ge};
                r_low[s+1]  <= r_low[s];
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_cap[s+1]  <= r_cap[s];
                r_mode[s+1] <= r_mode[s];
            end
        end
    end

    // apply cap and sign
    always_ff @(posedge i_clk) begin
        logic [CLIP_W-1:0] v_mag;
        if (i_en) begin
            if (r_cap[QUO_W]) begin
                v_mag = r_mode[QUO_W] ? CLIP_W'(1) << 31 : CLIP_W'(1) << 47;
            end else begin
                v_mag = CLIP_W'(r_quo[QUO_W]);
            end
            r_out <= r_neg[QUO_W] ? -$signed(v_mag) : $signed(v_mag);
        end
    end

    assign o_quo = r_out;

endmodule

// ===== hdl/wtsp_back.sv =====
// back end: perspective divide, viewport mapping, output register
// depends on wtsp_pkg and wtsp_div
module wtsp_back import wtsp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_clip                     i_clip,
    input  t_fifo_status              i_q_status,
    output logic                      o_pop,
    input  logic [VP_W-1:0]           i_vp_width,
    input  logic [VP_W-1:0]           i_vp_height,
    input  logic [PRR_W-1:0]          i_prr,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_screen_x,
    output logic signed [COORD_W-1:0] o_screen_y,
    output logic signed [COORD_W-1:0] o_depth,
    output logic                      o_fault
);

    logic                      w_en;
    logic                      r_vld [DIV_STAGES];
    logic                      r_flt [DIV_STAGES];
    logic signed [CLIP_W-1:0]  w_dx;
    logic signed [CLIP_W-1:0]  w_dy;
    logic signed [CLIP_W-1:0]  w_dz;
    logic                      r_v1;
    logic                      r_f1;
    logic signed [PIX_W-1:0]   r_px;
    logic signed [PIX_W-1:0]   r_py;
    logic signed [COORD_W-1:0] r_dz;
    logic                      r_ov;
    logic                      r_of;
    logic signed [COORD_W-1:0] r_sx;
    logic signed [COORD_W-1:0] r_sy;
    logic signed [COORD_W-1:0] r_dzo;

    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en && !i_q_status.empty;

    wtsp_div u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_clip.cx), .i_den(i_clip.cw),
        .i_depth_mode(1'b0), .o_quo(w_dx)
    );
    wtsp_div u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_clip.cy), .i_den(i_clip.cw),
        .i_depth_mode(1'b0), .o_quo(w_dy)
    );
    wtsp_div u_div_z (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_clip.cz), .i_den(i_clip.cw),
        .i_depth_mode(1'b1), .o_quo(w_dz)
    );

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SCALE_W-1:0] v);
        if (v > SCALE_W'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -SCALE_W'(33'sh0_8000_0000)) begin
            return 32'sh8000_0000;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    function automatic logic signed [SCALE_W-1:0] scale(input logic signed [PIX_W-1:0] p,
                                                         input logic [PRR_W-1:0] prr);
        logic signed [PIXC_W-1:0]  v_c;
        logic signed [SCALE_W-1:0] v_m;
        if (p > (PIX_W'(1) <<< 47)) begin
            v_c = PIXC_W'(1) <<< 47;
        end else if (p < -(PIX_W'(1) <<< 47)) begin
            v_c = -(PIXC_W'(1) <<< 47);
        end else begin
            v_c = p[PIXC_W-1:0];
        end
        v_m = v_c * $signed({1'b0, prr});
        return v_m >>> 15;
    endfunction

    // divide pipeline tracking
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flt[0] <= i_clip.cw == '0;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_flt[s] <= r_flt[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= o_pop;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_v1 <= r_vld[DIV_STAGES-1];
            r_ov <= r_v1;
        end
    end

    // viewport products
    always_ff @(posedge i_clk) begin
        logic signed [CLIP_W:0] v_ax;
        logic signed [CLIP_W:0] v_ay;
        logic signed [CLIP_W:0] v_one;
        if (w_en) begin
            v_one = (CLIP_W+1)'(1) <<< DX_FRAC;
            v_ax  = (CLIP_W+1)'(w_dx) + v_one;
            v_ay  = v_one - (CLIP_W+1)'(w_dy);
            r_px  <= v_ax * $signed({1'b0, i_vp_width});
            r_py  <= v_ay * $signed({1'b0, i_vp_height});
            r_dz  <= sat32(SCALE_W'(w_dz));
            r_f1  <= r_flt[DIV_STAGES-1];
        end
    end

    // pixel-ratio scaling into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_of <= r_f1;
            if (r_f1) begin
                r_sx  <= '0;
                r_sy  <= '0;
                r_dzo <= '0;
            end else begin
                r_sx  <= sat32(scale(r_px, i_prr));
                r_sy  <= sat32(scale(r_py, i_prr));
                r_dzo <= r_dz;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_fault    = r_of;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_depth    = r_dzo;

endmodule
